### src/lirs_pkg.sv
`default_nettype none
package lirs_pkg;

    // sample and rate register widths fixed by the stream format
    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 16;
    localparam int RESET_RATE  = 24000;
    localparam int MAX_RESULTS = 63;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [RATE_W-1:0]          t_rate;

endpackage
`default_nettype wire

### src/lirs_ser_mul.sv
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module lirs_ser_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic                    o_done,
    output logic [A_W+B_W-1:0]      o_prod
);

    localparam int CW = $clog2(B_W + 1);

    logic [A_W-1:0] r_a;
    logic [A_W-1:0] r_hi;
    logic [B_W-1:0] r_lo;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [A_W:0]   sum;

    // add the multiplicand when the current multiplier bit is set
    assign sum = r_lo[0] ? ({1'b0, r_hi} + {1'b0, r_a}) : {1'b0, r_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum[A_W:1];
            r_lo <= {sum[0], r_lo[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule
`default_nettype wire

### src/lirs_ser_div.sv
`default_nettype none
// Restoring divider by a constant, one quotient bit per cycle, MSB first.
// The numerator must stay below DIVISOR * 2**Q_W so the quotient fits Q_W bits.
module lirs_ser_div #(
    parameter int N_W     = 32,
    parameter int Q_W     = 16,
    parameter int DIVISOR = 44100
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    output logic                o_done,
    output logic [Q_W-1:0]      o_quot
);

    localparam int R_W = N_W - Q_W;
    localparam int CW  = $clog2(Q_W + 1);

    logic [R_W-1:0] r_rem;
    logic [Q_W-1:0] r_q;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [R_W:0]   trial;
    logic           ge;

    // shift the next numerator bit into the partial remainder
    assign trial = {r_rem, r_q[Q_W-1]};
    assign ge    = trial >= (R_W+1)'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[N_W-1:Q_W];
            r_q   <= i_num[Q_W-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? R_W'(trial - (R_W+1)'(DIVISOR)) : trial[R_W-1:0];
            r_q   <= {r_q[Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

### src/linear_interp_resampler_unit.sv
`default_nettype none
// Flow: a priming beat is only stored; every later input beat passes S_CHECK and then, per result,
//   the bit-serial multiplier ($clog2(OUT_RATE) steps), the bit-serial divider (16 steps) and
//   S_EMIT, where a stalled output register can hold the finished result.
// o_in_stall holds off the next input beat until all results of the current beat are emitted.
// Reset (synchronous, active low): rate 24000, previous sample 0, no primed sample,
//   phase 0, output register empty.
module linear_interp_resampler_unit #(
    parameter int OUT_RATE = 44100
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: input sample rate in Hz
    input  wire logic                          i_cfg_we,
    input  wire logic [lirs_pkg::RATE_W-1:0]   i_cfg_wdata,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [lirs_pkg::SAMPLE_W-1:0] i_in_sample,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                               o_run_last
);

    localparam int SW = lirs_pkg::SAMPLE_W;
    localparam int RW = lirs_pkg::RATE_W;
    // phase used in a product is below OUT_RATE
    localparam int PW = $clog2(OUT_RATE);
    // phase between beats stays below OUT_RATE + 2**RATE_W
    localparam int AW = $clog2(OUT_RATE + (1 << RW));
    localparam int MIN_RATE = (OUT_RATE + lirs_pkg::MAX_RESULTS - 1) / lirs_pkg::MAX_RESULTS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic               r_have_prev, n_have_prev;
    lirs_pkg::t_sample  r_prev, n_prev;
    lirs_pkg::t_sample  r_cur, n_cur;
    logic [AW-1:0]      r_phase, n_phase;
    lirs_pkg::t_rate    r_rate, n_rate;
    logic               r_out_valid, n_out_valid;
    lirs_pkg::t_sample  r_out_sample, n_out_sample;
    logic               r_run_last, n_run_last;

    logic               in_fire;
    logic               emit_fire;
    logic               mul_start, mul_done;
    logic               div_start, div_done;
    logic [SW:0]        delta;
    logic [SW-1:0]      mag;
    logic [SW+PW-1:0]   prod;
    logic [SW-1:0]      quot;
    logic [SW:0]        interp;
    lirs_pkg::t_rate    rate_eff;
    logic [AW-1:0]      phase_adv;

    // Accept input only between beats; the output register decouples the far side.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;

    // Floor the rate so one beat never yields more than the result limit.
    assign rate_eff  = (r_rate < RW'(MIN_RATE)) ? RW'(MIN_RATE) : r_rate;
    assign phase_adv = r_phase + AW'(rate_eff);

    // Interpolate on magnitudes: truncation toward zero falls out of the unsigned divide.
    assign delta  = {r_cur[SW-1], r_cur} - {r_prev[SW-1], r_prev};
    assign mag    = delta[SW] ? SW'(-delta) : delta[SW-1:0];
    assign interp = {r_prev[SW-1], r_prev} +
                    (delta[SW] ? -{1'b0, quot} : {1'b0, quot});

    assign mul_start = (r_state == S_CHECK) && (r_phase < AW'(OUT_RATE));
    assign div_start = (r_state == S_MUL) && mul_done;
    // Hold the finished result until the output register is free.
    assign emit_fire = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    lirs_ser_mul #(
        .A_W (SW),
        .B_W (PW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mag),
        .i_b     (r_phase[PW-1:0]),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    lirs_ser_div #(
        .N_W     (SW + PW),
        .Q_W     (SW),
        .DIVISOR (OUT_RATE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        n_state      = r_state;
        n_have_prev  = r_have_prev;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_phase      = r_phase;
        n_rate       = r_rate;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_run_last   = r_run_last;

        if (i_cfg_we) begin
            n_rate = i_cfg_wdata;
        end

        // drop the output beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (!r_have_prev) begin
                        // priming beat: store only
                        n_prev      = i_in_sample;
                        n_have_prev = 1'b1;
                    end else begin
                        n_cur   = i_in_sample;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (mul_start) begin
                    n_state = S_MUL;
                end else begin
                    // run over: wrap the phase and advance the sample pair
                    n_phase = r_phase - AW'(OUT_RATE);
                    n_prev  = r_cur;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = interp[SW-1:0];
                    n_run_last   = (phase_adv >= AW'(OUT_RATE));
                    n_phase      = phase_adv;
                    n_state      = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have_prev  <= 1'b0;
            r_prev       <= '0;
            r_cur        <= '0;
            r_phase      <= '0;
            r_rate       <= RW'(lirs_pkg::RESET_RATE);
            r_out_valid  <= 1'b0;
            r_out_sample <= '0;
            r_run_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_have_prev  <= n_have_prev;
            r_prev       <= n_prev;
            r_cur        <= n_cur;
            r_phase      <= n_phase;
            r_rate       <= n_rate;
            r_out_valid  <= n_out_valid;
            r_out_sample <= n_out_sample;
            r_run_last   <= n_run_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_run_last   = r_run_last;

    // Serial units report completion only in the state that waits for them.
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiplier finished outside its wait state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // A result is formed only from a phase inside the current input interval.
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |-> (r_phase < AW'(OUT_RATE)))
        else $error("result emitted with phase past the interval");

    // The interpolated value lies between the two neighboring samples.
    a_emit_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |->
            (($signed(interp[SW-1:0]) >= r_prev && $signed(interp[SW-1:0]) <= r_cur) ||
             ($signed(interp[SW-1:0]) <= r_prev && $signed(interp[SW-1:0]) >= r_cur)))
        else $error("interpolated sample outside its neighbors");

    // A held output beat is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_sample)))
        else $error("stalled output beat overwritten");

endmodule
`default_nettype wire

### tb/sv/tb_linear_interp_resampler_unit.sv
`default_nettype none
module tb_linear_interp_resampler_unit;

    localparam int OUT_RATE  = 44100;
    // rate floor: no input may cause more than MAX_RESULTS output beats
    localparam int MIN_RATE  = (OUT_RATE + lirs_pkg::MAX_RESULTS - 1) / lirs_pkg::MAX_RESULTS;
    localparam int SETTLE_CYC = 64;      // drain time for a beat that yields nothing
    localparam int HOLD_CYC   = 600;     // long output back-pressure stretch
    localparam int WDOG_LIMIT = 5000;    // cycles without any beat before giving up
    localparam int RAND_PER_PHASE = 130;
    localparam int N_DIR = 25;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    lirs_pkg::t_rate   i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    lirs_pkg::t_sample i_in_sample = '0;
    logic              i_out_stall = 1'b0;

    logic              o_in_stall;
    logic              o_out_valid;
    lirs_pkg::t_sample o_out_sample;
    logic              o_run_last;

    always #2 i_clk = ~i_clk;

    linear_interp_resampler_unit #(
        .OUT_RATE (OUT_RATE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_sample  (i_in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample),
        .o_run_last   (o_run_last)
    );

    // ------------------------------------------------------------------
    // Interpolator predictor: its own copy of rate, previous sample,
    // primed flag and phase, plus the queue of expected output beats.
    // ------------------------------------------------------------------
    typedef struct packed {
        lirs_pkg::t_sample smp;
        logic              run_last;
    } t_interp;

    t_interp interp_q[$];

    lirs_pkg::t_rate   rate_reg    = lirs_pkg::t_rate'(lirs_pkg::RESET_RATE);
    lirs_pkg::t_sample pred_prev   = '0;
    bit                pred_primed = 1'b0;
    int                pred_phase  = 0;

    int n_errors     = 0;
    int n_in_beats   = 0;
    int n_out_beats  = 0;
    int n_zero_runs  = 0;
    int n_full_runs  = 0;
    int n_cfg_writes = 0;
    int src_idle_pct  = 26;
    int sink_idle_pct = 62;
    int hold_left     = 0;

    // Advance the predictor by one accepted input beat. With queue_it low the
    // state still moves but the caller has already queued typed-in results.
    function automatic void interp_predict(input lirs_pkg::t_sample cur, input bit queue_it);
        int      eff;
        int      n;
        longint  delta;
        longint  v;
        t_interp r;
        eff = (int'(rate_reg) < MIN_RATE) ? MIN_RATE : int'(rate_reg);
        n   = 0;
        if (!pred_primed) begin
            // priming beat: store only, nothing comes out
            pred_prev   = cur;
            pred_primed = 1'b1;
            return;
        end
        while (pred_phase < OUT_RATE && n < lirs_pkg::MAX_RESULTS) begin
            delta = longint'(cur) - longint'(pred_prev);
            // product is wide; signed divide truncates toward zero
            v = longint'(pred_prev) + (delta * longint'(pred_phase)) / OUT_RATE;
            r.smp      = lirs_pkg::t_sample'(v[15:0]);
            r.run_last = !((pred_phase + eff < OUT_RATE) && (n + 1 < lirs_pkg::MAX_RESULTS));
            if (queue_it)
                interp_q.push_back(r);
            n++;
            pred_phase += eff;
        end
        pred_phase = (pred_phase >= OUT_RATE) ? pred_phase - OUT_RATE : 0;
        pred_prev  = cur;
        if (n == 0)
            n_zero_runs++;
        if (n == lirs_pkg::MAX_RESULTS)
            n_full_runs++;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Called at a falling edge; returns at a falling edge.
    // Valid stays high into the next beat unless an idle cycle is rolled,
    // so each step sees at most one assignment to it.
    // ------------------------------------------------------------------
    task automatic offer_beat(input lirs_pkg::t_sample smp, input bit predict);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_sample <= smp;
        // hold the payload until the block takes it
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        n_in_beats++;
        interp_predict(smp, predict);
        @(negedge i_clk);
    endtask

    // Write the rate register only with the block idle: drain every expected
    // beat, then give a trailing zero-result beat time to finish.
    task automatic write_rate(input lirs_pkg::t_rate r);
        i_in_valid <= 1'b0;
        while (interp_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rate_reg = r;
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall, or a long hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Output checker: compare each accepted beat with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_interp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_out_beats++;
            if (interp_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected output beat, expected none got sample %0d last %0b",
                         $time, o_out_sample, o_run_last);
            end else begin
                want = interp_q.pop_front();
                if (o_out_sample !== want.smp) begin
                    n_errors++;
                    $display("%0t: out_sample mismatch, expected %0d got %0d",
                             $time, want.smp, o_out_sample);
                end
                if (o_run_last !== want.run_last) begin
                    n_errors++;
                    $display("%0t: run_last mismatch, expected %0b got %0b",
                             $time, want.run_last, o_run_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a beat.
    // ------------------------------------------------------------------
    int quiet_cyc = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc == WDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d beats still expected",
                     $time, WDOG_LIMIT, interp_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table. Typed rows run at rate 44100 from phase zero, where
    // every beat after priming returns exactly the previous sample.
    // ------------------------------------------------------------------
    typedef enum logic [0:0] {ROW_RATE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind kind;
        int        value;
        bit        typed;
        int        exp_n;
        int        exp_smp;
    } t_dir_row;

    t_dir_row dir_tab [N_DIR] = '{
        '{ROW_RATE,   44100,  1'b0, 0, 0},
        '{ROW_SAMPLE, 32767,  1'b1, 0, 0},       // priming beat, no output
        '{ROW_SAMPLE, -32768, 1'b1, 1, 32767},
        '{ROW_SAMPLE, 0,      1'b1, 1, -32768},
        '{ROW_SAMPLE, -1,     1'b1, 1, 0},
        '{ROW_SAMPLE, 32767,  1'b1, 1, -1},
        '{ROW_SAMPLE, 1,      1'b1, 1, 32767},
        '{ROW_SAMPLE, -21846, 1'b1, 1, 1},
        '{ROW_SAMPLE, 21845,  1'b1, 1, -21846},
        '{ROW_RATE,   65535,  1'b0, 0, 0},       // fast rate: phase runs past OUT_RATE
        '{ROW_SAMPLE, -32768, 1'b0, 0, 0},
        '{ROW_SAMPLE, 32767,  1'b0, 0, 0},
        '{ROW_SAMPLE, 0,      1'b0, 0, 0},
        '{ROW_SAMPLE, -32768, 1'b0, 0, 0},       // lands with no output at all
        '{ROW_RATE,   0,      1'b0, 0, 0},       // below the floor: clamped
        '{ROW_SAMPLE, -32768, 1'b0, 0, 0},
        '{ROW_SAMPLE, 32767,  1'b0, 0, 0},       // full run of MAX_RESULTS beats
        '{ROW_RATE,   700,    1'b0, 0, 0},
        '{ROW_SAMPLE, -32768, 1'b0, 0, 0},
        '{ROW_RATE,   44101,  1'b0, 0, 0},
        '{ROW_SAMPLE, 100,    1'b0, 0, 0},
        '{ROW_SAMPLE, -100,   1'b0, 0, 0},
        '{ROW_SAMPLE, 5,      1'b0, 0, 0},
        '{ROW_RATE,   24000,  1'b0, 0, 0},
        '{ROW_SAMPLE, 1234,   1'b0, 0, 0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_interp           typed_beat;
        int                sel;
        int                seg_len;
        int                wave;
        int                walk;
        lirs_pkg::t_rate   r;
        lirs_pkg::t_sample smp;
        bit                hold_done;

        hold_done = 1'b0;
        walk      = 0;

        // hold reset low from time zero, then release it at a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed pass (first idling mix)
        for (int i = 0; i < N_DIR; i++) begin
            if (dir_tab[i].kind == ROW_RATE) begin
                write_rate(lirs_pkg::t_rate'(dir_tab[i].value));
            end else if (dir_tab[i].typed) begin
                if (dir_tab[i].exp_n == 1) begin
                    typed_beat.smp      = lirs_pkg::t_sample'(dir_tab[i].exp_smp);
                    typed_beat.run_last = 1'b1;
                    interp_q.push_back(typed_beat);
                end
                offer_beat(lirs_pkg::t_sample'(dir_tab[i].value), 1'b0);
            end else begin
                offer_beat(lirs_pkg::t_sample'(dir_tab[i].value), 1'b1);
            end
        end

        // random part in three idling mixes: sender-light, receiver-light, none
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 26 : (ph == 1) ? 62 : 0;
            sink_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 26 : 0;
            for (int sent = 0; sent < RAND_PER_PHASE; sent += seg_len) begin
                // pick a rate; keep slow-rate segments short since they are costly
                sel = $urandom_range(99);
                if (sel < 60)
                    r = lirs_pkg::t_rate'($urandom_range(44100, 8000));
                else if (sel < 75)
                    r = lirs_pkg::t_rate'($urandom_range(65535, 44101));
                else if (sel < 87)
                    r = lirs_pkg::t_rate'($urandom_range(7999, 700));
                else if (sel < 94)
                    r = lirs_pkg::t_rate'($urandom_range(699, 0));
                else
                    r = lirs_pkg::t_rate'($urandom());
                seg_len = (r < 8000) ? $urandom_range(4, 1) : $urandom_range(20, 8);
                write_rate(r);

                // once, with the sender never idle: hold off the output for a
                // long stretch so the block fills and stalls its input
                if (ph == 2 && !hold_done) begin
                    @(posedge i_clk);
                    hold_left = HOLD_CYC;
                    hold_done = 1'b1;
                    @(negedge i_clk);
                end

                wave = $urandom_range(3);
                for (int k = 0; k < seg_len; k++) begin
                    case (wave)
                        0: begin
                            // smooth walk, clamped to the sample range
                            walk += int'($urandom_range(4095)) - 2048;
                            if (walk > 32767)
                                walk = 32767;
                            if (walk < -32768)
                                walk = -32768;
                            smp = lirs_pkg::t_sample'(walk);
                        end
                        1: begin
                            smp = lirs_pkg::t_sample'($urandom());
                        end
                        2: begin
                            // rail-to-rail swings for the widest deltas
                            case ($urandom_range(3))
                                0: smp = 16'sh7FFF;
                                1: smp = 16'sh8000;
                                2: smp = 16'sh0000;
                                default: smp = 16'shFFFF;
                            endcase
                        end
                        default: begin
                            // square wave with random amplitude
                            smp = lirs_pkg::t_sample'($urandom_range(32767));
                            if (k % 2 == 1)
                                smp = -smp;
                        end
                    endcase
                    offer_beat(smp, 1'b1);
                end
            end
        end

        // drop valid, drain what is expected, then watch for stray beats
        i_in_valid <= 1'b0;
        while (interp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Covered %0d input beats and %0d output beats over %0d rate writes;",
                 n_in_beats, n_out_beats, n_cfg_writes);
        $display("%0d inputs gave no output, %0d gave a full run of %0d, %0d mismatches.",
                 n_zero_runs, n_full_runs, lirs_pkg::MAX_RESULTS, n_errors);
        if (n_errors == 0 && interp_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
